FILE: hdl/ewfm_pkg.sv
// Package for the exposure weighted frame mean unit: widths, reset values,
// register indexes, state encodings and the control struct. No dependencies.
`default_nettype none

package ewfm_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 262144;
  localparam int unsigned MAX_GROUP_DEF  = 64;

  localparam int unsigned DATA_W     = 24;  // signal, exposure, mean
  localparam int unsigned PROD_W     = 48;  // signal times exposure
  localparam int unsigned PSUM_W     = 56;  // product accumulator
  localparam int unsigned ETOT_W     = 32;  // exposure accumulator
  localparam int unsigned ACC_W      = PSUM_W + ETOT_W + 1;
  localparam int unsigned FPG_W      = 7;
  localparam int unsigned PPF_W      = 19;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUOT_W     = 24;  // quotient bits kept by the divider
  localparam int unsigned NUM_W      = PSUM_W + 2;
  localparam int unsigned DEN_W      = ETOT_W + 1;

  localparam logic [FPG_W-1:0]  FPG_RESET     = 7'd1;
  localparam logic [PPF_W-1:0]  PPF_RESET     = 19'd262144;
  localparam logic [DATA_W-1:0] INVALID_RESET = 24'hD8F100;  // -9999.0 in Q.8

  localparam logic [DATA_W-1:0] MEAN_MAX = 24'h7FFFFF;
  localparam logic [DATA_W-1:0] MEAN_MIN = 24'h800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_PER_GROUP = 2'd0,
    REG_PIXELS_PER_FRAME = 2'd1,
    REG_INVALID_CODE     = 2'd2
  } cfg_reg_e;

  // Classification of one accepted pixel pair.
  typedef struct packed {
    logic pair_ok;      // neither value equals the invalid code
    logic first_frame;  // first frame of a group: accumulators start afresh
    logic last_frame;   // last frame of a group: the pixel yields a result
    logic last_pix;     // last pixel of its frame
  } ctl_t;

  localparam int unsigned CTL_W = $bits(ctl_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACC,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MAG,
    DV_SUM,
    DV_CHK,
    DV_RUN,
    DV_DONE
  } div_state_e;

endpackage

`default_nettype wire

FILE: hdl/ewfm_ram.sv
// Generic single port write, single port read RAM with registered read data.
// No dependencies.
`default_nettype none

module ewfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/ewfm_front.sv
// Front end: configuration registers, pixel and frame counters, and the
// classification of each accepted pair. Depends on ewfm_pkg.
`default_nettype none

module ewfm_front import ewfm_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int unsigned MAX_GROUP  = MAX_GROUP_DEF,
  localparam int unsigned PXW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [DATA_W-1:0]     signal_i,
  input  wire logic [DATA_W-1:0]     exposure_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output ctl_t                       ctl_o,
  output logic      [PXW-1:0]        idx_o
);

  localparam int unsigned FGW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned PLW = ($clog2(MAX_PIXELS + 1) > PPF_W) ?
                                $clog2(MAX_PIXELS + 1) : PPF_W;
  localparam int unsigned GLW = ($clog2(MAX_GROUP + 1) > FPG_W) ?
                                $clog2(MAX_GROUP + 1) : FPG_W;

  logic [FPG_W-1:0]  fpg_q;
  logic [PPF_W-1:0]  ppf_q;
  logic [DATA_W-1:0] inv_q;
  logic [PXW-1:0]    pix_q;
  logic [FGW-1:0]    frm_q;

  logic [PLW-1:0] ppf_ext, ppf_eff;
  logic [GLW-1:0] fpg_ext, fpg_eff;
  logic           last_pix, last_frame;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;

  // Out of range sizes are clamped to one and to the largest supported value.
  always_comb begin
    ppf_ext = PLW'(ppf_q);
    fpg_ext = GLW'(fpg_q);
    if (ppf_ext == '0) begin
      ppf_eff = PLW'(1);
    end else if (ppf_ext > PLW'(MAX_PIXELS)) begin
      ppf_eff = PLW'(MAX_PIXELS);
    end else begin
      ppf_eff = ppf_ext;
    end
    if (fpg_ext == '0) begin
      fpg_eff = GLW'(1);
    end else if (fpg_ext > GLW'(MAX_GROUP)) begin
      fpg_eff = GLW'(MAX_GROUP);
    end else begin
      fpg_eff = fpg_ext;
    end
  end

  assign last_pix   = (PLW'(pix_q) + PLW'(1)) >= ppf_eff;
  assign last_frame = (GLW'(frm_q) + GLW'(1)) >= fpg_eff;

  always_comb begin
    ctl_o.pair_ok     = (signal_i != inv_q) && (exposure_i != inv_q);
    ctl_o.first_frame = (frm_q == '0);
    ctl_o.last_frame  = last_frame;
    ctl_o.last_pix    = last_pix;
  end

  assign idx_o = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpg_q <= FPG_RESET;
      ppf_q <= PPF_RESET;
      inv_q <= INVALID_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAMES_PER_GROUP: fpg_q <= cfg_data_i[FPG_W-1:0];
        REG_PIXELS_PER_FRAME: ppf_q <= cfg_data_i[PPF_W-1:0];
        REG_INVALID_CODE:     inv_q <= cfg_data_i[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
      frm_q <= '0;
    end else if (push_o) begin
      if (last_pix) begin
        pix_q <= '0;
        frm_q <= last_frame ? '0 : frm_q + FGW'(1);
      end else begin
        pix_q <= pix_q + PXW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ewfm_queue.sv
// Short queue between the front end and the back end.
// Depends on ewfm_pkg for its default depth.
`default_nettype none

module ewfm_queue import ewfm_pkg::*; #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic      [DW-1:0] rdata_o,
  output logic               empty_o
);

  logic [DW-1:0] slot_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;

  assign full_o  = (count_q == (AW + 1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (AW + 1)'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> full_o || $past(push_i) == 1'b0)
    else $error("queue lost its full state while nothing was popped");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

FILE: hdl/ewfm_div.sv
// Sequential rounding divider for the weighted mean: magnitude, rounding
// offset, overflow check, then one quotient bit per cycle. Depends on ewfm_pkg.
`default_nettype none

module ewfm_div import ewfm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PSUM_W-1:0] psum_i,
  input  wire logic [ETOT_W-1:0] esum_i,
  output logic                   done_o,
  output logic      [DATA_W-1:0] mean_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  div_state_e st_q, st_d;

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [QUOT_W-1:0] sh_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q, ovf_q;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, sh_q[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      DV_IDLE: if (start_i) begin
        st_d = DV_MAG;
      end
      DV_MAG:  st_d = DV_SUM;
      DV_SUM:  st_d = DV_CHK;
      DV_CHK:  st_d = (num_q >= NUM_W'({den_q, {QUOT_W{1'b0}}})) ? DV_DONE : DV_RUN;
      DV_RUN:  if (cnt_q == CNT_W'(1)) begin
        st_d = DV_DONE;
      end
      DV_DONE: st_d = DV_IDLE;
      default: st_d = DV_IDLE;
    endcase
  end

  // The quotient is below 2^24 unless overflow was flagged, so it fits 24 bits.
  always_comb begin
    done_o = (st_q == DV_DONE);
    if (ovf_q) begin
      mean_o = neg_q ? MEAN_MIN : MEAN_MAX;
    end else if (neg_q) begin
      mean_o = (sh_q > MEAN_MIN) ? MEAN_MIN : DATA_W'(-sh_q);
    end else begin
      mean_o = (sh_q > MEAN_MAX) ? MEAN_MAX : sh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DV_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      DV_IDLE: if (start_i) begin
        num_q <= NUM_W'(psum_i);
        den_q <= DEN_W'(esum_i);
        neg_q <= psum_i[PSUM_W-1] ^ esum_i[ETOT_W-1];
      end
      DV_MAG: begin
        if (num_q[PSUM_W-1]) begin
          num_q <= NUM_W'(PSUM_W'(~num_q[PSUM_W-1:0]) + PSUM_W'(1));
        end
        if (den_q[ETOT_W-1]) begin
          den_q <= DEN_W'(ETOT_W'(~den_q[ETOT_W-1:0]) + ETOT_W'(1));
        end
      end
      DV_SUM: begin
        // Round half away from zero: (2n + d) / (2d).
        num_q <= {num_q[NUM_W-2:0], 1'b0} + NUM_W'(den_q);
        den_q <= {den_q[DEN_W-2:0], 1'b0};
      end
      DV_CHK: begin
        ovf_q <= num_q >= NUM_W'({den_q, {QUOT_W{1'b0}}});
        rem_q <= num_q[NUM_W-2:QUOT_W];
        sh_q  <= num_q[QUOT_W-1:0];
        cnt_q <= CNT_W'(QUOT_W);
      end
      DV_RUN: begin
        rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        sh_q  <= {sh_q[QUOT_W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      DV_DONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/ewfm_back.sv
// Back end: accumulator memory, multiply and accumulate, divider control and
// the output register. Depends on ewfm_pkg, ewfm_ram and ewfm_div.
`default_nettype none

module ewfm_back import ewfm_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  localparam int unsigned PXW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     hd_valid_i,
  output logic                          pop_o,
  input  wire logic signed [DATA_W-1:0] hd_sig_i,
  input  wire logic signed [DATA_W-1:0] hd_exp_i,
  input  wire logic        [PXW-1:0]    hd_idx_i,
  input  wire ctl_t                     hd_ctl_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic             [DATA_W-1:0] weighted_mean_o,
  output logic             [ETOT_W-1:0] exposure_total_o,
  output logic                          no_valid_frame_o,
  output logic                          last_pixel_o
);

  back_state_e st_q, st_d;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [DATA_W-1:0] exp_q;
  logic        [PXW-1:0]    idx_q;
  ctl_t                     ctl_q;

  logic [ACC_W-1:0]  rd_data, wr_data;
  logic              ram_re, ram_we;
  logic [PSUM_W-1:0] base_p, sum_p;
  logic [ETOT_W-1:0] base_e, sum_e;
  logic              base_s, sum_s;
  logic              need_div;

  logic              div_start, div_done;
  logic [DATA_W-1:0] div_mean;

  logic [DATA_W-1:0] mean_q;
  logic [ETOT_W-1:0] etot_q;
  logic              nv_q, lp_q;

  logic              out_valid_q, out_nv_q, out_lp_q, out_load, out_free;
  logic [DATA_W-1:0] out_mean_q;
  logic [ETOT_W-1:0] out_etot_q;

  ewfm_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_PIXELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_data),
    .re_i    (ram_re),
    .raddr_i (hd_idx_i),
    .rdata_o (rd_data)
  );

  ewfm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .psum_i  (sum_p),
    .esum_i  (sum_e),
    .done_o  (div_done),
    .mean_o  (div_mean)
  );

  // Entry layout: {valid seen, exposure sum, product sum}.
  always_comb begin
    if (ctl_q.first_frame) begin
      {base_s, base_e, base_p} = '0;
    end else begin
      {base_s, base_e, base_p} = rd_data;
    end
    sum_p    = base_p + (ctl_q.pair_ok ? PSUM_W'(prod_q) : '0);
    sum_e    = base_e + (ctl_q.pair_ok ? ETOT_W'(exp_q) : '0);
    sum_s    = base_s | ctl_q.pair_ok;
    wr_data  = {sum_s, sum_e, sum_p};
    need_div = ctl_q.last_frame && sum_s && (sum_e != '0);
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (hd_valid_i) begin
        st_d = BK_ACC;
      end
      BK_ACC: begin
        if (!ctl_q.last_frame) begin
          st_d = BK_IDLE;
        end else if (need_div) begin
          st_d = BK_DIV;
        end else begin
          st_d = BK_OUT;
        end
      end
      BK_DIV: if (div_done) begin
        st_d = BK_OUT;
      end
      BK_OUT: if (out_free) begin
        st_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        pop_o  = hd_valid_i;
        ram_re = hd_valid_i;
      end
      BK_ACC: begin
        ram_we    = 1'b1;
        div_start = need_div;
      end
      BK_DIV: ;
      BK_OUT: out_load = out_free;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= hd_sig_i * hd_exp_i;
      exp_q  <= hd_exp_i;
      idx_q  <= hd_idx_i;
      ctl_q  <= hd_ctl_i;
    end
    if (st_q == BK_ACC && ctl_q.last_frame) begin
      etot_q <= sum_e;
      nv_q   <= !sum_s;
      lp_q   <= ctl_q.last_pix;
      mean_q <= '0;
    end else if (st_q == BK_DIV && div_done) begin
      mean_q <= div_mean;
    end
    if (out_load) begin
      out_mean_q <= mean_q;
      out_etot_q <= etot_q;
      out_nv_q   <= nv_q;
      out_lp_q   <= lp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign weighted_mean_o  = out_mean_q;
  assign exposure_total_o = out_etot_q;
  assign no_valid_frame_o = out_nv_q;
  assign last_pixel_o     = out_lp_q;

  a_div_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> st_q == BK_DIV)
    else $error("divider finished while the back end was not waiting for it");

  a_result_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == BK_OUT)
    else $error("result appeared without passing the output state");

  a_hold_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_OUT && out_valid_q && !out_ready_i |=> st_q == BK_OUT)
    else $error("result dropped while the output register was occupied");

endmodule

`default_nettype wire

FILE: hdl/exposure_weighted_frame_mean_unit.sv
// Top level of the exposure weighted frame mean unit: front end, queue and
// back end. Depends on ewfm_pkg, ewfm_front, ewfm_queue and ewfm_back.
//
//   Channel   Direction  Handshake                 Payload
//   cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o   signal_i, exposure_i
//   out       out        out_valid_o / out_ready_i weighted_mean_o,
//                                                  exposure_total_o,
//                                                  no_valid_frame_o,
//                                                  last_pixel_o
//
// For a pixel outside the last frame of a group the back end first reads the
// accumulator memory and multiplies, then adds and writes back. A pixel of
// the last frame that needs a division then waits for the divider, which
// retires one of 24 quotient bits per cycle after its magnitude, rounding
// offset and overflow check states; it skips the quotient bits and saturates
// when the quotient overflows. With no division the result goes to the output.
// The four entry queue keeps accepting pairs while the back end or the output
// register is stalled; the output register holds one finished transaction.
// Reset clears the counters, the control state and the queue, and gives the
// configuration registers their reset values; the accumulator memory needs
// no clearing pass as the first frame of a group writes every entry it uses.
`default_nettype none

module exposure_weighted_frame_mean_unit import ewfm_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int unsigned MAX_GROUP  = MAX_GROUP_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] signal_i,
  input  wire logic signed [DATA_W-1:0] exposure_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      weighted_mean_o,
  output logic signed [ETOT_W-1:0]      exposure_total_o,
  output logic                          no_valid_frame_o,
  output logic                          last_pixel_o
);

  localparam int unsigned PXW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned QW  = CTL_W + PXW + 2 * DATA_W;

  logic          push, q_full, q_empty, pop;
  ctl_t          fe_ctl, hd_ctl;
  logic [PXW-1:0] fe_idx, hd_idx;
  logic [QW-1:0] q_wdata, q_rdata;
  logic signed [DATA_W-1:0] hd_sig, hd_exp;

  // The front end counts positions and classifies each pair as it is accepted.
  ewfm_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_GROUP  (MAX_GROUP)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .signal_i    (signal_i),
    .exposure_i  (exposure_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .ctl_o       (fe_ctl),
    .idx_o       (fe_idx)
  );

  assign q_wdata = {fe_ctl, fe_idx, signal_i, exposure_i};

  // Decouples acceptance from the multi-cycle work of the back end.
  ewfm_queue #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign {hd_ctl, hd_idx, hd_sig, hd_exp} = q_rdata;

  // The back end accumulates per pixel and produces one result transaction for
  // each pixel of the last frame in a group.
  ewfm_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hd_valid_i       (!q_empty),
    .pop_o            (pop),
    .hd_sig_i         (hd_sig),
    .hd_exp_i         (hd_exp),
    .hd_idx_i         (hd_idx),
    .hd_ctl_i         (hd_ctl),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .weighted_mean_o  (weighted_mean_o),
    .exposure_total_o (exposure_total_o),
    .no_valid_frame_o (no_valid_frame_o),
    .last_pixel_o     (last_pixel_o)
  );

endmodule

`default_nettype wire

FILE: test/tb_exposure_weighted_frame_mean_unit.sv
// Self-checking testbench for exposure_weighted_frame_mean_unit: drives pixel pairs
// and register writes, and predicts every weighted mean in a small scoreboard.
// Depends on ewfm_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_exposure_weighted_frame_mean_unit;
  import ewfm_pkg::*;

  // A watchdog ends the run after this many cycles in which no transaction
  // happens on any channel. The longest quiet stretch of a correct run is the
  // receiver hold-off, so this is ample headroom.
  localparam int STALL_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 400;
  // Cycles left after the last expected result before the unit counts as idle.
  // Pairs outside the last frame of a group give no result but still pass the
  // four entry queue and the back end.
  localparam int DRAIN_CYCLES    = 100;
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_PIXELS    = 90;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic signed [DATA_W-1:0] mean;
    logic signed [ETOT_W-1:0] total;
    logic                     no_valid;
    logic                     last;
  } pixel_result_t;

  // The scoreboard keeps its own copy of the registers, the pixel and frame
  // counters and the per-pixel accumulators. Each accepted pair updates them;
  // a pair of the last frame of a group queues the result that it must give.
  class mean_scoreboard;
    logic [FPG_W-1:0]  frames_per_group;
    logic [PPF_W-1:0]  pixels_per_frame;
    logic [DATA_W-1:0] invalid_code;
    bit [PSUM_W-1:0]   product_acc [int];
    bit [ETOT_W-1:0]   exposure_acc [int];
    bit                seen_acc [int];
    int unsigned       pixel_pos;
    int unsigned       frame_pos;
    pixel_result_t     pending_means [$];
    int                errors;

    function new();
      frames_per_group = FPG_RESET;
      pixels_per_frame = PPF_RESET;
      invalid_code     = INVALID_RESET;
      pixel_pos        = 0;
      frame_pos        = 0;
      errors           = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_FRAMES_PER_GROUP: frames_per_group = value[FPG_W-1:0];
        REG_PIXELS_PER_FRAME: pixels_per_frame = value[PPF_W-1:0];
        REG_INVALID_CODE:     invalid_code = value[DATA_W-1:0];
        default: ;
      endcase
    endfunction

    function bit at_group_start();
      return pixel_pos == 0 && frame_pos == 0;
    endfunction

    // Product sum over exposure sum, rounded to nearest with ties away from
    // zero, then saturated to the mean's range.
    function logic signed [DATA_W-1:0] rounded_ratio(longint num, longint den);
      longint unsigned n, d, q;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      if (d == 0) begin
        return '0;
      end
      q = (2 * n + d) / (2 * d);
      if ((num < 0) != (den < 0)) begin
        return (q > 64'd8388608) ? MEAN_MIN : DATA_W'(64'd0 - q);
      end
      return (q > 64'd8388607) ? MEAN_MAX : DATA_W'(q);
    endfunction

    function void note_pixel(logic signed [DATA_W-1:0] sig,
                             logic signed [DATA_W-1:0] expo);
      int unsigned   group_len, frame_len;
      bit [PSUM_W-1:0] psum;
      bit [ETOT_W-1:0] esum;
      bit            seen, last_pix, last_frame;
      longint        prod;
      pixel_result_t res;
      group_len = (frames_per_group == 0) ? 1 :
                  (frames_per_group > MAX_GROUP_DEF) ? MAX_GROUP_DEF : frames_per_group;
      frame_len = (pixels_per_frame == 0) ? 1 :
                  (pixels_per_frame > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : pixels_per_frame;
      // The first frame of a group starts the accumulators afresh.
      if (frame_pos == 0) begin
        psum = '0;
        esum = '0;
        seen = 1'b0;
      end else begin
        psum = product_acc[int'(pixel_pos)];
        esum = exposure_acc[int'(pixel_pos)];
        seen = seen_acc[int'(pixel_pos)];
      end
      if (sig != invalid_code && expo != invalid_code) begin
        prod = longint'(sig) * longint'(expo);
        psum = psum + prod[PSUM_W-1:0];
        esum = esum + {{(ETOT_W - DATA_W){expo[DATA_W-1]}}, expo};
        seen = 1'b1;
      end
      product_acc[int'(pixel_pos)]  = psum;
      exposure_acc[int'(pixel_pos)] = esum;
      seen_acc[int'(pixel_pos)]     = seen;
      last_pix   = pixel_pos + 1 >= frame_len;
      last_frame = frame_pos + 1 >= group_len;
      if (last_pix) begin
        pixel_pos = 0;
        frame_pos = last_frame ? 0 : frame_pos + 1;
      end else begin
        pixel_pos++;
      end
      if (last_frame) begin
        res.mean     = seen ? rounded_ratio(longint'($signed(psum)),
                                            longint'($signed(esum))) : '0;
        res.total    = esum;
        res.no_valid = !seen;
        res.last     = last_pix;
        pending_means = {pending_means, res};
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_means.size() == 0) begin
        $error("result with no pixel pending: weighted_mean %0d", got.mean);
        errors++;
        return;
      end
      want = pending_means.pop_front();
      if (got.mean !== want.mean) begin
        $error("weighted_mean: expected %0d, actual %0d", want.mean, got.mean);
        errors++;
      end
      if (got.total !== want.total) begin
        $error("exposure_total: expected %0d, actual %0d", want.total, got.total);
        errors++;
      end
      if (got.no_valid !== want.no_valid) begin
        $error("no_valid_frame: expected %0b, actual %0b", want.no_valid, got.no_valid);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_pixel: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] signal_i = '0;
  logic signed [DATA_W-1:0] exposure_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] weighted_mean_o;
  logic signed [ETOT_W-1:0] exposure_total_o;
  logic                     no_valid_frame_o;
  logic                     last_pixel_o;

  mean_scoreboard board = new();
  pixel_result_t  out_sample;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  bit             hold_off_req = 1'b0;
  int             quiet_cycles = 0;

  // Settings of the random phases. Group lengths of 0 and above 64 and frame
  // sizes of 0 and above the maximum check the clamping of the registers.
  int fpg_sel [RANDOM_PHASES] = '{1, 2, 3, 64, 4, 0, 8, 127, 2, 5, 1, 3};
  int ppf_sel [RANDOM_PHASES] = '{262144, 7, 4, 1, 12, 0, 3, 1, 5, 16, 524287, 9};

  exposure_weighted_frame_mean_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .signal_i         (signal_i),
    .exposure_i       (exposure_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .weighted_mean_o  (weighted_mean_o),
    .exposure_total_o (exposure_total_o),
    .no_valid_frame_o (no_valid_frame_o),
    .last_pixel_o     (last_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every accepted result transaction is checked against the oldest
  // prediction. Outputs are read right after the rising edge, before the
  // unit's registers take their new values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      out_sample = '{weighted_mean_o, exposure_total_o, no_valid_frame_o, last_pixel_o};
      board.check_result(out_sample);
    end
  end

  // The watchdog restarts its count on any transaction of any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver stalls at random at the rate of the current phase. On request
  // it holds ready low for a long stretch so that the queue and the output
  // register fill up and the unit has to stall its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 64; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // One register write transaction; the scoreboard takes the new value once
  // the unit has accepted it.
  task automatic cfg_write(cfg_reg_e idx, int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, CFG_DATA_W'(value));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one pixel pair after a random number of idle cycles and returns
  // once the pair has been accepted. Valid is left high so that the next pair
  // follows without a gap when the sender does not idle.
  task automatic push_pixel(int sig, int expo);
    logic signed [DATA_W-1:0] s, e;
    s = DATA_W'(sig);
    e = DATA_W'(expo);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    signal_i   <= s;
    exposure_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel(s, e);
  endtask

  // Waits until every predicted result has come back and the last pairs that
  // give no result have left the pipeline.
  task automatic drain_unit();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Registers change only while the unit is idle. A new frame size is only
  // safe at the start of a group: otherwise a later frame could read an
  // accumulator entry that this group never wrote. When a phase stopped in
  // the middle of a group, one pair sent with a group length and a frame size
  // of one closes the group and brings both counters back to zero. That pair
  // also covers register changes in the middle of a frame and of a group.
  task automatic configure_unit(int fpg, int ppf, int inv);
    drain_unit();
    if (!board.at_group_start()) begin
      cfg_write(REG_FRAMES_PER_GROUP, 1);
      cfg_write(REG_PIXELS_PER_FRAME, 1);
      push_pixel($urandom, $urandom);
      drain_unit();
    end
    cfg_write(REG_FRAMES_PER_GROUP, fpg);
    cfg_write(REG_PIXELS_PER_FRAME, ppf);
    cfg_write(REG_INVALID_CODE, inv);
  endtask

  // Random field value: the invalid code now and then, the extremes, small
  // values that keep the means in range, and full 24-bit patterns.
  function automatic int rand_field(logic [DATA_W-1:0] inv, bit positive);
    int unsigned pick;
    int          small_val;
    pick = $urandom_range(99);
    small_val = $urandom_range(8191);
    if (pick < 8) begin
      return $signed(inv);
    end
    if (pick < 14) begin
      case ($urandom_range(4))
        0:       return 8388607;
        1:       return -8388608;
        2:       return 0;
        3:       return 1;
        default: return -1;
      endcase
    end
    if (pick < 55) begin
      return positive ? small_val + 1 : small_val - 4096;
    end
    return $urandom;
  endfunction

  initial begin
    int inv;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers still at their reset values: one frame per group, the
    // default invalid code on either field.
    set_idling(IDLE_NONE);
    push_pixel(25600, 512);
    push_pixel($signed(INVALID_RESET), 256);
    push_pixel(1000, $signed(INVALID_RESET));

    // Three frames of two pixels with zero as the invalid code. Pixel 0 never
    // has a valid pair; pixel 1 has valid pairs whose exposures cancel.
    configure_unit(3, 2, 0);
    set_idling(IDLE_BOTH);
    push_pixel(0, 300);
    push_pixel(1000, 256);
    push_pixel(500, 0);
    push_pixel(-700, -256);
    push_pixel(0, 0);
    push_pixel(0, 77);

    // Mixed-sign exposures drive the mean past both ends of its range.
    configure_unit(2, 1, -8388608);
    set_idling(IDLE_SENDER);
    push_pixel(8388607, 2);
    push_pixel(-8388607, -1);
    push_pixel(-8388607, 2);
    push_pixel(8388607, -1);
    push_pixel(8388607, 8388607);
    push_pixel(-8388607, 8388607);

    // Zero register values act as one; the most negative fields are valid.
    configure_unit(0, 0, 8388607);
    set_idling(IDLE_RECEIVER);
    push_pixel(-8388608, -8388608);
    push_pixel(-8388608, 1);
    push_pixel(1, -8388608);

    // Oversized registers clamp to the largest group and frame; these pairs
    // start a group that is never finished and so give no result.
    configure_unit(127, 524287, $urandom);
    set_idling(IDLE_NONE);
    repeat (3) push_pixel($urandom, $urandom);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k % 4)
        0:       inv = $signed(INVALID_RESET);
        1:       inv = $urandom;
        2:       inv = (k < 6) ? -8388608 : 8388607;
        default: inv = 0;
      endcase
      configure_unit(fpg_sel[k], ppf_sel[k], inv);
      set_idling(idle_mode_e'(k % 4));
      // The first random phase gives a result for every pair, so a long
      // receiver hold-off there backs the pipeline up to the input.
      if (k == 0) begin
        hold_off_req = 1'b1;
      end
      repeat (PHASE_PIXELS) begin
        push_pixel(rand_field(board.invalid_code, 1'b0),
                   rand_field(board.invalid_code, 1'b1));
      end
    end

    drain_unit();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ewfm_pkg.sv
hdl/ewfm_ram.sv
hdl/ewfm_front.sv
hdl/ewfm_queue.sv
hdl/ewfm_div.sv
hdl/ewfm_back.sv
hdl/exposure_weighted_frame_mean_unit.sv
test/tb_exposure_weighted_frame_mean_unit.sv
